// ----- rtl/core/alt_shk_pkg.sv -----
// shared codes and helpers for the alternating shaker sequencer
`default_nettype none

package alt_shk_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_RUN    = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_RESET  = 3'd3;
  localparam logic [2:0] CMD_M1_ON  = 3'd4;
  localparam logic [2:0] CMD_M1_OFF = 3'd5;
  localparam logic [2:0] CMD_M2_ON  = 3'd6;
  localparam logic [2:0] CMD_M2_OFF = 3'd7;

  // sequencer phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_ON    = 2'd2;
  localparam logic [1:0] PH_OFF   = 2'd3;

  // motor masks
  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_ONE  = 2'd1;
  localparam logic [1:0] MOTOR_TWO  = 2'd2;
  localparam logic [1:0] MOTOR_BOTH = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_ON_TIME    = 3'd0;
  localparam logic [2:0] REG_OFF_TIME   = 3'd1;
  localparam logic [2:0] REG_LOOP_LIMIT = 3'd2;
  localparam logic [2:0] REG_SHAKE_ALWS = 3'd3;
  localparam logic [2:0] REG_BLOCK_TIME = 3'd4;

  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned MS_W       = 26;   // 65535 s in ms fits in 26 bits

  typedef logic [MS_W-1:0] ms_t;

  // seconds to milliseconds, a constant multiply
  function automatic ms_t sec_to_ms(input logic [15:0] sec);
    sec_to_ms = ms_t'({10'd0, sec} * ms_t'(MS_PER_SEC));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/alternating_shaker_sequencer.sv -----
// Alternating shaker sequencer top level
// Path: input register, then state register, which doubles as the result register.
// Throughput: one item per cycle unless the output stalls.
// Time compares use thresholds converted to milliseconds when a register is written,
// so each item costs one subtract per timer and one compare per threshold.
// Reset: asynchronous active low; config returns to defaults, phase idle, motors off.
`default_nettype none

module alternating_shaker_sequencer import alt_shk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] now_ms_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             motor_one_drive_o,
  output logic             motor_two_drive_o,
  output logic             run_active_o,
  output logic [7:0]       loop_progress_o,
  output logic [31:0]      total_shakes_o,
  output logic [31:0]      total_runs_o
);

  // configuration registers, times held in milliseconds
  ms_t        on_ms_q, off_ms_q, block_ms_q;
  logic [7:0] loop_limit_q;
  logic       shake_always_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_ms_q        <= sec_to_ms(16'd10);
      off_ms_q       <= sec_to_ms(16'd30);
      loop_limit_q   <= 8'd3;
      shake_always_q <= 1'b0;
      block_ms_q     <= sec_to_ms(16'd5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ON_TIME:    on_ms_q        <= sec_to_ms(cfg_data_i);
        REG_OFF_TIME:   off_ms_q       <= sec_to_ms(cfg_data_i);
        REG_LOOP_LIMIT: loop_limit_q   <= cfg_data_i[7:0];
        REG_SHAKE_ALWS: shake_always_q <= cfg_data_i[0];
        REG_BLOCK_TIME: block_ms_q     <= sec_to_ms(cfg_data_i);
        default: ;
      endcase
    end
  end

  // handshake control
  logic        s0_valid_q, out_valid_q;
  logic [2:0]  s0_cmd_q;
  logic [31:0] s0_now_q;
  logic        advance, s0_take, s0_fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s0_valid_q && !advance;
  assign s0_take    = in_valid_i && !in_stall_o;
  assign s0_fire    = s0_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_take) begin
        s0_valid_q <= 1'b1;
      end else if (s0_fire) begin
        s0_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s0_valid_q;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s0_take) begin
      s0_cmd_q <= command_i;
      s0_now_q <= now_ms_i;
    end
  end

  // sequencer state
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  active_q, active_d;
  logic [1:0]  drive_q, drive_d;
  logic [31:0] phase_stamp_q, phase_stamp_d;
  logic [31:0] block_stamp_q, block_stamp_d;
  logic        block_valid_q, block_valid_d;
  logic [7:0]  loop_q, loop_d;
  logic [31:0] shakes_q, shakes_d;
  logic [31:0] runs_q, runs_d;
  logic        running_q, running_d;

  // timer compares
  logic [31:0] phase_elapsed, block_elapsed;
  logic        on_done, off_done, blocked, on_ok;
  logic [1:0]  active_inc;
  logic [7:0]  loop_inc;

  assign phase_elapsed = s0_now_q - phase_stamp_q;
  assign block_elapsed = s0_now_q - block_stamp_q;
  assign on_done       = phase_elapsed >= {6'd0, on_ms_q};
  assign off_done      = phase_elapsed >= {6'd0, off_ms_q};
  assign blocked       = block_valid_q && (block_elapsed < {6'd0, block_ms_q});
  assign on_ok         = (drive_q == MOTOR_NONE) && !blocked;
  assign active_inc    = active_q + 2'd1;
  assign loop_inc      = loop_q + 8'd1;

  // next state for one item
  always_comb begin
    phase_d       = phase_q;
    active_d      = active_q;
    drive_d       = drive_q;
    phase_stamp_d = phase_stamp_q;
    block_stamp_d = block_stamp_q;
    block_valid_d = block_valid_q;
    loop_d        = loop_q;
    shakes_d      = shakes_q;
    runs_d        = runs_q;
    running_d     = running_q;

    unique case (s0_cmd_q) inside
      CMD_TICK: begin
        unique case (phase_q)
          PH_ARMED: begin
            runs_d        = runs_q + 32'd1;
            phase_stamp_d = s0_now_q;
            loop_d        = 8'd0;
            phase_d       = PH_ON;
            running_d     = 1'b1;
            active_d      = MOTOR_ONE;
            if (on_ok) begin
              drive_d = drive_q | MOTOR_ONE;
            end
          end
          PH_ON: begin
            if (on_done) begin
              // switch-off at end of on phase
              if (drive_q != MOTOR_NONE) begin
                block_stamp_d = s0_now_q;
                block_valid_d = 1'b1;
              end
              drive_d  = drive_q & ~active_q;
              active_d = (active_inc == MOTOR_BOTH) ? MOTOR_ONE : active_inc;
              shakes_d = shakes_q + 32'd1;
              if (!shake_always_q && (loop_inc >= loop_limit_q)) begin
                loop_d    = loop_inc;
                phase_d   = PH_IDLE;
                running_d = 1'b0;
              end else begin
                if (!shake_always_q) begin
                  loop_d = loop_inc;
                end
                phase_d       = PH_OFF;
                phase_stamp_d = s0_now_q;
              end
            end
          end
          PH_OFF: begin
            if (off_done) begin
              if (on_ok) begin
                drive_d = drive_q | active_q;
              end
              phase_d       = PH_ON;
              phase_stamp_d = s0_now_q;
            end
          end
          default: ;
        endcase
      end
      CMD_RUN: begin
        phase_d = PH_ARMED;
      end
      CMD_STOP, CMD_RESET: begin
        if (drive_q != MOTOR_NONE) begin
          block_stamp_d = s0_now_q;
          block_valid_d = 1'b1;
        end
        drive_d   = MOTOR_NONE;
        phase_d   = PH_IDLE;
        running_d = 1'b0;
        if (s0_cmd_q == CMD_RESET) begin
          runs_d   = 32'd0;
          shakes_d = 32'd0;
          loop_d   = 8'd0;
        end
      end
      CMD_M1_ON, CMD_M2_ON: begin
        if (on_ok) begin
          drive_d = drive_q | ((s0_cmd_q == CMD_M1_ON) ? MOTOR_ONE : MOTOR_TWO);
        end
      end
      default: begin
        // manual switch-off of one motor
        if (drive_q != MOTOR_NONE) begin
          block_stamp_d = s0_now_q;
          block_valid_d = 1'b1;
        end
        drive_d = drive_q & ~((s0_cmd_q == CMD_M1_OFF) ? MOTOR_ONE : MOTOR_TWO);
      end
    endcase
  end

  // state register, also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      active_q      <= MOTOR_NONE;
      drive_q       <= MOTOR_NONE;
      phase_stamp_q <= 32'd0;
      block_stamp_q <= 32'd0;
      block_valid_q <= 1'b0;
      loop_q        <= 8'd0;
      shakes_q      <= 32'd0;
      runs_q        <= 32'd0;
      running_q     <= 1'b0;
    end else if (s0_fire) begin
      phase_q       <= phase_d;
      active_q      <= active_d;
      drive_q       <= drive_d;
      phase_stamp_q <= phase_stamp_d;
      block_stamp_q <= block_stamp_d;
      block_valid_q <= block_valid_d;
      loop_q        <= loop_d;
      shakes_q      <= shakes_d;
      runs_q        <= runs_d;
      running_q     <= running_d;
    end
  end

  // result outputs
  assign out_valid_o       = out_valid_q;
  assign motor_one_drive_o = drive_q[0];
  assign motor_two_drive_o = drive_q[1];
  assign run_active_o      = running_q;
  assign loop_progress_o   = loop_q;
  assign total_shakes_o    = shakes_q;
  assign total_runs_o      = runs_q;

endmodule

`default_nettype wire
